@@ design/crt_pkg.sv @@
// shared types and codes for the two-moduli crt solver
package crt_pkg;
  localparam int MODULUS_BITS = 16;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_COPR = 2'd1,
    ST_ZERO_MOD = 2'd2
  } crt_status_t;
endpackage

@@ design/crt_two_moduli_solver_core.sv @@
// two-moduli chinese remainder solver: extended euclid plus serial modular reduction
//
// channel | direction | ports
// in      | input     | in_valid, in_ready, in_residue_a/b, in_modulus_m/n
// out     | output    | out_valid, out_ready, out_status, out_gcd_value, out_inverse_of_m/n,
//         |           | out_solution, out_combined_modulus
//
// one item at a time; each euclid step divides r0 by r1 at one quotient bit a cycle,
// then latches the quotient, then updates the remainders and both coefficients
// then three serial reductions run in turn: c*b mod n, d*a mod m, sum mod m*n
// rst_n is synchronous, active low; in_ready is high only in the idle state
// out_valid holds the result until the transfer; a stalled output blocks the next item
module crt_two_moduli_solver_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [31:0]     in_residue_a,
  input  logic signed [31:0]     in_residue_b,
  input  logic [15:0]            in_modulus_m,
  input  logic [15:0]            in_modulus_n,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_status,
  output logic [15:0]            out_gcd_value,
  output logic signed [16:0]     out_inverse_of_m,
  output logic signed [16:0]     out_inverse_of_n,
  output logic [31:0]            out_solution,
  output logic [31:0]            out_combined_modulus
);
  import crt_pkg::*;

  localparam int MB = MODULUS_BITS;
  localparam int CW = MB + 2;           // signed bezout coefficient width
  localparam int PW = 2 * MB;           // product width
  localparam int DW = PW + 34;          // dividend width for reductions
  localparam int DCW = $clog2(DW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_PROD, S_DIV, S_UPD_S, S_UPD_T, S_MUL1, S_RED1, S_MUL2, S_RED2,
    S_MUL3, S_RED3, S_DONE
  } state_t;

  state_t state_r;
  logic signed [31:0] a_r, b_r;
  logic [MB-1:0] m_r, n_r, r0_r, r1_r, q_r;
  logic signed [CW-1:0] s0_r, s1_r, t0_r, t1_r;
  logic [PW-1:0] prod_r, u_r;
  // serial reduction unit: shift-subtract remainder
  logic [DW-1:0] dvd_r;
  logic [PW:0] rem_r;
  logic [PW-1:0] dvs_r;
  logic dneg_r;
  logic [DCW-1:0] cnt_r;
  logic [1:0] status_r;
  logic [15:0] gcd_r;
  logic signed [16:0] c_o_r, d_o_r;
  logic [31:0] x_r, mn_r;

  // shared division step
  logic [PW+1:0] trial;
  logic [PW+1:0] shifted;
  assign shifted = {rem_r, dvd_r[DW-1]};
  assign trial = shifted - {2'b00, dvs_r};

  // remainder corrected for a negative dividend (floor mod)
  logic [PW-1:0] fmod_res;
  assign fmod_res = (dneg_r && rem_r[PW-1:0] != '0) ? dvs_r - rem_r[PW-1:0] : rem_r[PW-1:0];

  logic signed [CW+MB:0] qs, qt;
  assign qs = $signed({1'b0, q_r}) * s1_r;
  assign qt = $signed({1'b0, q_r}) * t1_r;
  logic signed [CW+32:0] mul_cb, mul_da;
  assign mul_cb = s0_r * b_r;
  assign mul_da = t0_r * a_r;
  logic [DW-1:0] mag_cb, mag_da;
  assign mag_cb = mul_cb[CW+32] ? DW'(-mul_cb) : DW'(mul_cb);
  assign mag_da = mul_da[CW+32] ? DW'(-mul_da) : DW'(mul_da);

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_status = status_r;
  assign out_gcd_value = gcd_r;
  assign out_inverse_of_m = c_o_r;
  assign out_inverse_of_n = d_o_r;
  assign out_solution = x_r;
  assign out_combined_modulus = mn_r;

  // sequencer with registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            a_r <= in_residue_a;
            b_r <= in_residue_b;
            m_r <= in_modulus_m[MB-1:0];
            n_r <= in_modulus_n[MB-1:0];
            r0_r <= in_modulus_m[MB-1:0];
            r1_r <= in_modulus_n[MB-1:0];
            s0_r <= CW'(1); s1_r <= '0; t0_r <= '0; t1_r <= CW'(1);
            state_r <= S_PROD;
          end
        end
        S_PROD: begin
          prod_r <= PW'(m_r) * PW'(n_r);
          mn_r <= 32'(PW'(m_r) * PW'(n_r));
          c_o_r <= '0; d_o_r <= '0; x_r <= '0;
          if (m_r == '0 || n_r == '0) begin
            // gcd with a zero modulus is the other modulus
            gcd_r <= 16'(m_r | n_r);
            status_r <= ST_ZERO_MOD;
            state_r <= S_DONE;
          end else begin
            dvd_r <= {r0_r, {(DW-MB){1'b0}}};
            rem_r <= '0; dvs_r <= PW'(r1_r); cnt_r <= DCW'(MB);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          // one quotient bit per cycle of r0 / r1
          dvd_r <= {dvd_r[DW-2:0], ~trial[PW+1]};
          rem_r <= trial[PW+1] ? shifted[PW:0] : trial[PW:0];
          cnt_r <= cnt_r - DCW'(1);
          if (cnt_r == DCW'(1)) state_r <= S_UPD_S;
        end
        S_UPD_S: begin
          q_r <= dvd_r[MB-1:0];
          state_r <= S_UPD_T;
        end
        S_UPD_T: begin
          s0_r <= s1_r; s1_r <= s0_r - CW'(qs);
          t0_r <= t1_r; t1_r <= t0_r - CW'(qt);
          r0_r <= r1_r; r1_r <= rem_r[MB-1:0];
          gcd_r <= 16'(r1_r);
          if (rem_r[MB-1:0] == '0) begin
            if (r1_r == MB'(1)) begin
              status_r <= ST_OK;
              c_o_r <= 17'(s1_r); d_o_r <= 17'(t1_r);
              state_r <= S_MUL1;
            end else begin
              status_r <= ST_NOT_COPR;
              state_r <= S_DONE;
            end
          end else begin
            dvd_r <= {r1_r, {(DW-MB){1'b0}}};
            rem_r <= '0; dvs_r <= PW'(rem_r[MB-1:0]); cnt_r <= DCW'(MB);
            state_r <= S_DIV;
          end
        end
        S_MUL1: begin
          // c*b mod n
          dvd_r <= mag_cb; dneg_r <= mul_cb[CW+32];
          rem_r <= '0; dvs_r <= PW'(n_r); cnt_r <= DCW'(DW);
          state_r <= S_RED1;
        end
        S_RED1: begin
          dvd_r <= {dvd_r[DW-2:0], 1'b0};
          rem_r <= trial[PW+1] ? shifted[PW:0] : trial[PW:0];
          cnt_r <= cnt_r - DCW'(1);
          if (cnt_r == DCW'(1)) state_r <= S_MUL2;
        end
        S_MUL2: begin
          u_r <= PW'(m_r) * fmod_res;
          dvd_r <= mag_da; dneg_r <= mul_da[CW+32];
          rem_r <= '0; dvs_r <= PW'(m_r); cnt_r <= DCW'(DW);
          state_r <= S_RED2;
        end
        S_RED2: begin
          dvd_r <= {dvd_r[DW-2:0], 1'b0};
          rem_r <= trial[PW+1] ? shifted[PW:0] : trial[PW:0];
          cnt_r <= cnt_r - DCW'(1);
          if (cnt_r == DCW'(1)) state_r <= S_MUL3;
        end
        S_MUL3: begin
          // m*u + n*v, then mod m*n
          dvd_r <= DW'({1'b0, u_r} + {1'b0, PW'(n_r) * fmod_res});
          dneg_r <= 1'b0;
          rem_r <= '0; dvs_r <= prod_r; cnt_r <= DCW'(DW);
          state_r <= S_RED3;
        end
        S_RED3: begin
          dvd_r <= {dvd_r[DW-2:0], 1'b0};
          rem_r <= trial[PW+1] ? shifted[PW:0] : trial[PW:0];
          cnt_r <= cnt_r - DCW'(1);
          if (cnt_r == DCW'(1)) begin
            // final remainder is the solution
            x_r <= 32'(trial[PW+1] ? shifted[PW-1:0] : trial[PW-1:0]);
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // checks
  a_ok_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_ZERO_MOD |-> out_combined_modulus == '0)
    else $error("zero modulus with nonzero product");
  a_hs_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> dvs_r != '0) else $error("division by zero");
endmodule

@@ dv/tb_crt_two_moduli_solver_core.sv @@
// testbench for the two-moduli crt solver: directed and random requests, checked per result
`timescale 1ns / 1ps

module tb_crt_two_moduli_solver_core;
  import crt_pkg::*;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        gcd_value;
    logic [16:0]        inv_m;
    logic [16:0]        inv_n;
    logic [31:0]        solution;
    logic [31:0]        combined;
  } crt_answer_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_residue_a = '0;
  logic signed [31:0] in_residue_b = '0;
  logic [15:0]        in_modulus_m = '0;
  logic [15:0]        in_modulus_n = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic [15:0]        out_gcd_value;
  logic signed [16:0] out_inverse_of_m;
  logic signed [16:0] out_inverse_of_n;
  logic [31:0]        out_solution;
  logic [31:0]        out_combined_modulus;

  crt_answer_t answer_q[$];
  int unsigned error_count = 0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  crt_two_moduli_solver_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_residue_a(in_residue_a), .in_residue_b(in_residue_b),
    .in_modulus_m(in_modulus_m), .in_modulus_n(in_modulus_n),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_gcd_value(out_gcd_value),
    .out_inverse_of_m(out_inverse_of_m), .out_inverse_of_n(out_inverse_of_n),
    .out_solution(out_solution), .out_combined_modulus(out_combined_modulus)
  );

  always #1 clk = ~clk;

  // floor-mod by a positive divisor
  function automatic longint floor_mod(longint v, longint k);
    longint r;
    r = v % k;
    if (r < 0) r += k;
    return r;
  endfunction

  // predicted crt answer for one request
  function automatic crt_answer_t solve_crt(logic signed [31:0] ra, logic signed [31:0] rb,
                                            logic [15:0] mm, logic [15:0] nn);
    crt_answer_t ans;
    longint a, b, m, n, x, y, t, r0, r1, s0, s1, t0, t1, q, tmp, u, v;
    a = ra; b = rb; m = mm; n = nn;
    x = m; y = n;
    while (y != 0) begin
      t = x % y; x = y; y = t;
    end
    ans = '0;
    ans.gcd_value = x[15:0];
    ans.combined = 32'(m * n);
    if (m == 0 || n == 0) begin
      ans.status = ST_ZERO_MOD;
    end else if (x != 1) begin
      ans.status = ST_NOT_COPR;
    end else begin
      ans.status = ST_OK;
      r0 = m; r1 = n; s0 = 1; s1 = 0; t0 = 0; t1 = 1;
      while (r1 != 0) begin
        q = r0 / r1;
        tmp = r0 - q * r1; r0 = r1; r1 = tmp;
        tmp = s0 - q * s1; s0 = s1; s1 = tmp;
        tmp = t0 - q * t1; t0 = t1; t1 = tmp;
      end
      ans.inv_m = s0[16:0];
      ans.inv_n = t0[16:0];
      u = floor_mod(s0 * b, n);
      v = floor_mod(t0 * a, m);
      ans.solution = 32'((m * u + n * v) % (m * n));
    end
    return ans;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("mismatch %0s at result %0d: got %0h want %0h", what, checked_count, got, want);
  endtask

  // push one request through the input channel; valid stays up into a back-to-back request
  task automatic send_request(logic [31:0] ra, logic [31:0] rb, logic [15:0] mm,
                              logic [15:0] nn);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    answer_q.push_back(solve_crt(ra, rb, mm, nn));
    in_valid <= 1'b1;
    in_residue_a <= ra; in_residue_b <= rb;
    in_modulus_m <= mm; in_modulus_n <= nn;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  // receiver backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    crt_answer_t want;
    if (rst_n && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = answer_q.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_gcd_value !== want.gcd_value)
          report_mismatch("gcd", out_gcd_value, want.gcd_value);
        if (out_inverse_of_m !== want.inv_m)
          report_mismatch("inverse_of_m", out_inverse_of_m, want.inv_m);
        if (out_inverse_of_n !== want.inv_n)
          report_mismatch("inverse_of_n", out_inverse_of_n, want.inv_n);
        if (out_solution !== want.solution)
          report_mismatch("solution", out_solution, want.solution);
        if (out_combined_modulus !== want.combined)
          report_mismatch("combined_modulus", out_combined_modulus, want.combined);
      end
      checked_count++;
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  // random modulus, mostly small, sometimes full width
  function automatic logic [15:0] pick_modulus();
    case ($urandom_range(9))
      0: return 16'($urandom_range(3));
      1, 2: return 16'($urandom);
      3: return 16'($urandom_range(65535, 65000));
      default: return 16'($urandom_range(300, 1));
    endcase
  endfunction

  task automatic test_directed();
    send_request(32'h7fffffff, 32'h80000000, 16'hffff, 16'hfffe);
    send_request(32'h80000000, 32'h7fffffff, 16'hfffe, 16'hffff);
    send_request(32'hffffffff, 32'hffffffff, 16'd1, 16'd1);
    send_request(32'd5, 32'd7, 16'd0, 16'd7);
    send_request(32'd5, 32'd7, 16'd9, 16'd0);
    send_request(32'd5, 32'd7, 16'd0, 16'd0);
    send_request(32'd3, 32'd4, 16'd6, 16'd9);
    send_request(32'd2, 32'd3, 16'd3, 16'd5);
    send_request(32'd2, 32'd3, 16'd5, 16'd3);
    send_request(-32'sd1, 32'd0, 16'd1, 16'd65535);
    send_request(32'd0, -32'sd1, 16'd65535, 16'd1);
    send_request(32'h55555555, 32'haaaaaaaa, 16'd46368, 16'd28657);
    send_request(32'haaaaaaaa, 32'h55555555, 16'hffff, 16'hffff);
    send_request(32'd0, 32'd0, 16'h8000, 16'h7fff);
    wait_drained();
  endtask

  task automatic test_random(int unsigned count, int unsigned idle, int unsigned stall);
    logic [15:0] mm, nn;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (count) begin
      mm = pick_modulus();
      nn = pick_modulus();
      // favor coprime pairs so the full solve path runs
      if ($urandom_range(3) != 0 && mm > 1 && nn > 1 && mm[0] == nn[0] && !mm[0]) nn[0] = 1'b1;
      send_request($urandom, $urandom, mm, nn);
    end
    wait_drained();
  endtask

  // sender holds off until every result is back
  task automatic test_drain_pause();
    send_request($urandom, $urandom, 16'd7, 16'd11);
    send_request($urandom, $urandom, 16'd13, 16'd17);
    wait_drained();
    repeat (20) @(posedge clk);
    send_request($urandom, $urandom, 16'd255, 16'd256);
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(300, 0, 0);
    test_random(250, 74, 0);
    test_random(250, 0, 74);
    test_drain_pause();
    test_random(250, 7, 7);
    repeat (600) @(posedge clk);
    $display("sent %0d requests, checked %0d results over four idling phases",
             sent_count, checked_count);
    if (error_count == 0 && answer_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("timeout with %0d results outstanding", answer_q.size());
    $display("Regression FAIL");
    $finish;
  end
endmodule

@@ files.f @@
design/crt_pkg.sv
design/crt_two_moduli_solver_core.sv
dv/tb_crt_two_moduli_solver_core.sv
